FILE: design/hsvc_pkg.sv
// ----------------------------------------------------------------------------
// hsvc_pkg
// Shared types for the HSV to RGB converter: pixel payloads on the two
// channels, the hue sector code, and the per-stage pipeline records.
// ----------------------------------------------------------------------------
package hsvc_pkg;

    // Hue decoding constants
    localparam int unsigned DEG_PER_SECTOR = 60;
    localparam int unsigned HUE_LIMIT      = 360;
    localparam int unsigned FULL_SCALE     = 255;
    localparam int unsigned SECTOR_SCALE   = DEG_PER_SECTOR * FULL_SCALE;

    // Input item: hue in degrees, saturation and value with 255 = 1.0
    typedef struct packed {
        logic [8:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } hsv_pixel_t;

    // Result item
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       bad_hue;
    } rgb_pixel_t;

    // Sixty-degree hue sector; codes 6 and 7 carry no meaning
    typedef enum logic [2:0] {
        SECTOR_RED_YELLOW    = 3'd0,
        SECTOR_YELLOW_GREEN  = 3'd1,
        SECTOR_GREEN_CYAN    = 3'd2,
        SECTOR_CYAN_BLUE     = 3'd3,
        SECTOR_BLUE_MAGENTA  = 3'd4,
        SECTOR_MAGENTA_RED   = 3'd5
    } sector_t;

    // Stage 1: hue split into sector and remainder
    typedef struct packed {
        sector_t    sector;
        logic [5:0] rem;
        logic       bad;
        logic [7:0] sat;
        logic [7:0] val;
    } st1_t;

    // Stage 2: multipliers of the value term
    typedef struct packed {
        sector_t     sector;
        logic        bad;
        logic [7:0]  val;
        logic [7:0]  fac_p;
        logic [13:0] fac_q;
        logic [13:0] fac_t;
    } st2_t;

    // Stage 3: undivided products
    typedef struct packed {
        sector_t     sector;
        logic        bad;
        logic [7:0]  val;
        logic [15:0] prod_p;
        logic [21:0] prod_q;
        logic [21:0] prod_t;
    } st3_t;

    // Stage 4: truncated quotients
    typedef struct packed {
        sector_t    sector;
        logic       bad;
        logic [7:0] val;
        logic [7:0] term_p;
        logic [7:0] term_q;
        logic [7:0] term_t;
    } st4_t;

endpackage

FILE: design/hsvc_stream_if.sv
// ----------------------------------------------------------------------------
// hsvc_stream_if
// Valid/ready channel carrying one pixel item of a chosen payload type.
// ----------------------------------------------------------------------------
interface hsvc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/hsv_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// Six-sector HSV to RGB conversion in a five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   hsv : sink channel, one pixel item (hue, saturation, brightness) per
//         valid/ready handshake. Hue 360..511 flags bad_hue with zero colour.
//   rgb : source channel, one result item (red, green, blue, bad_hue) for
//         every accepted pixel, in order.
//   Stages, each registered, in order: hue decode, factor multiply, value
//   multiply, reciprocal multiply for the two constant divides, sector
//   routing into the output register.
//   Throughput is one item per cycle while rgb.ready stays high; stages 2
//   to 4 each hold one multiplier level.
//   Each stage has its own valid bit and loads when empty or when the stage
//   after it moves, so bubbles close up and the input keeps taking items
//   while a finished result waits at the output.
//   When rgb.ready is low the output holds; hsv.ready drops only once every
//   stage is full.
//   Reset clears all valid bits; the pipeline then comes up empty and ready.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core
    import hsvc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    hsvc_stream_if.sink   hsv,
    hsvc_stream_if.source rgb
);

    localparam int unsigned NUM_STAGES = 5;

    // Reciprocals for exact floor division over the product ranges
    localparam int unsigned      SHIFT_Q = 36;
    localparam int unsigned      SHIFT_P = 24;
    localparam logic [63:0]      RECIP_Q_W =
        ((64'd1 << SHIFT_Q) + 64'(SECTOR_SCALE) - 64'd1) / 64'(SECTOR_SCALE);
    localparam logic [63:0]      RECIP_P_W =
        ((64'd1 << SHIFT_P) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
    localparam logic [22:0]      RECIP_Q = RECIP_Q_W[22:0];
    localparam logic [16:0]      RECIP_P = RECIP_P_W[16:0];

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] adv;

    st1_t       st1_reg, st1_next;
    st2_t       st2_reg, st2_next;
    st3_t       st3_reg, st3_next;
    st4_t       st4_reg, st4_next;
    rgb_pixel_t out_reg, out_next;

    logic [44:0] mul_q;
    logic [44:0] mul_t;
    logic [32:0] mul_p;
    logic [8:0]  hue_base;

    // Advance chain: a stage loads when empty or when its successor moves
    always_comb
    begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || rgb.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign hsv.ready = adv[0];

    // Move valid bits along with the data
    always_comb
    begin
        vld_next = vld_reg;
        if (adv[0])
        begin
            vld_next[0] = hsv.valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (adv[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: split hue into sector and remainder
    always_comb
    begin
        st1_next.bad = (hsv.data.hue >= 9'(HUE_LIMIT));
        st1_next.sat = hsv.data.saturation;
        st1_next.val = hsv.data.brightness;
        priority if (hsv.data.hue >= 9'd300)
        begin
            st1_next.sector = SECTOR_MAGENTA_RED;
            hue_base        = 9'd300;
        end
        else if (hsv.data.hue >= 9'd240)
        begin
            st1_next.sector = SECTOR_BLUE_MAGENTA;
            hue_base        = 9'd240;
        end
        else if (hsv.data.hue >= 9'd180)
        begin
            st1_next.sector = SECTOR_CYAN_BLUE;
            hue_base        = 9'd180;
        end
        else if (hsv.data.hue >= 9'd120)
        begin
            st1_next.sector = SECTOR_GREEN_CYAN;
            hue_base        = 9'd120;
        end
        else if (hsv.data.hue >= 9'd60)
        begin
            st1_next.sector = SECTOR_YELLOW_GREEN;
            hue_base        = 9'd60;
        end
        else
        begin
            st1_next.sector = SECTOR_RED_YELLOW;
            hue_base        = 9'd0;
        end
        st1_next.rem = 6'(hsv.data.hue - hue_base);
    end

    // Stage 2: form the factors that scale the value
    always_comb
    begin
        st2_next.sector = st1_reg.sector;
        st2_next.bad    = st1_reg.bad;
        st2_next.val    = st1_reg.val;
        st2_next.fac_p  = 8'(FULL_SCALE) - st1_reg.sat;
        st2_next.fac_q  = 14'(SECTOR_SCALE) - 14'(st1_reg.sat) * 14'(st1_reg.rem);
        st2_next.fac_t  = 14'(SECTOR_SCALE)
                        - 14'(st1_reg.sat) * 14'(6'(DEG_PER_SECTOR) - st1_reg.rem);
    end

    // Stage 3: multiply by the value
    always_comb
    begin
        st3_next.sector = st2_reg.sector;
        st3_next.bad    = st2_reg.bad;
        st3_next.val    = st2_reg.val;
        st3_next.prod_p = 16'(st2_reg.val) * 16'(st2_reg.fac_p);
        st3_next.prod_q = 22'(st2_reg.val) * 22'(st2_reg.fac_q);
        st3_next.prod_t = 22'(st2_reg.val) * 22'(st2_reg.fac_t);
    end

    // Stage 4: divide by the constant scales through exact reciprocals
    always_comb
    begin
        mul_p = 33'(st3_reg.prod_p) * 33'(RECIP_P);
        mul_q = 45'(st3_reg.prod_q) * 45'(RECIP_Q);
        mul_t = 45'(st3_reg.prod_t) * 45'(RECIP_Q);
        st4_next.sector = st3_reg.sector;
        st4_next.bad    = st3_reg.bad;
        st4_next.val    = st3_reg.val;
        st4_next.term_p = mul_p[SHIFT_P+7:SHIFT_P];
        st4_next.term_q = mul_q[SHIFT_Q+7:SHIFT_Q];
        st4_next.term_t = mul_t[SHIFT_Q+7:SHIFT_Q];
    end

    // Stage 5: route terms to channels by sector, zero on a bad hue
    always_comb
    begin
        out_next.bad_hue = st4_reg.bad;
        unique case (st4_reg.sector)
            SECTOR_RED_YELLOW:
            begin
                out_next.red   = st4_reg.val;
                out_next.green = st4_reg.term_t;
                out_next.blue  = st4_reg.term_p;
            end
            SECTOR_YELLOW_GREEN:
            begin
                out_next.red   = st4_reg.term_q;
                out_next.green = st4_reg.val;
                out_next.blue  = st4_reg.term_p;
            end
            SECTOR_GREEN_CYAN:
            begin
                out_next.red   = st4_reg.term_p;
                out_next.green = st4_reg.val;
                out_next.blue  = st4_reg.term_t;
            end
            SECTOR_CYAN_BLUE:
            begin
                out_next.red   = st4_reg.term_p;
                out_next.green = st4_reg.term_q;
                out_next.blue  = st4_reg.val;
            end
            SECTOR_BLUE_MAGENTA:
            begin
                out_next.red   = st4_reg.term_t;
                out_next.green = st4_reg.term_p;
                out_next.blue  = st4_reg.val;
            end
            default:
            begin
                out_next.red   = st4_reg.val;
                out_next.green = st4_reg.term_p;
                out_next.blue  = st4_reg.term_q;
            end
        endcase
        if (st4_reg.bad)
        begin
            out_next.red   = '0;
            out_next.green = '0;
            out_next.blue  = '0;
        end
    end

    // Payload registers: load whenever the stage advances
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            st1_reg <= st1_next;
        end
        if (adv[1])
        begin
            st2_reg <= st2_next;
        end
        if (adv[2])
        begin
            st3_reg <= st3_next;
        end
        if (adv[3])
        begin
            st4_reg <= st4_next;
        end
        if (adv[4])
        begin
            out_reg <= out_next;
        end
    end

    assign rgb.valid = vld_reg[NUM_STAGES-1];
    assign rgb.data  = out_reg;

endmodule

FILE: design/hsvc_checker.sv
// ----------------------------------------------------------------------------
// hsvc_checker
// Port-level checks for the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsvc_checker
    import hsvc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input rgb_pixel_t out_data
);

    // A flagged hue carries no colour
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.bad_hue) |->
            (out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0))
        else $error("bad_hue item carries nonzero colour");

    // A free output implies the whole pipe can move, so input is open
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output is ready");

    // Pipeline comes out of reset empty
    assert property (@(posedge clk)
        $past(!rst_n) |-> !out_valid)
        else $error("output valid right after reset");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed or dropped");

endmodule

bind hsv_to_rgb_converter_core hsvc_checker u_hsvc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (hsv.ready),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .out_data  (rgb.data)
);

FILE: sim/hsv_to_rgb_converter_core_tb.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core_tb
// Checks the HSV to RGB pipeline against its own copy of the six-sector
// mapping. Pixels go in on the hsv channel with random idle gaps. Results
// come back on the rgb channel under random stalls and one long output hold.
// Each result is compared field by field with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core_tb
    import hsvc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PERCENT   = 32;
    localparam int HOLD_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    logic clk;
    logic rst_n;

    hsvc_stream_if #(.payload_t(hsv_pixel_t)) hsv_ch ();
    hsvc_stream_if #(.payload_t(rgb_pixel_t)) rgb_ch ();

    hsv_to_rgb_converter_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hsv   (hsv_ch),
        .rgb   (rgb_ch)
    );

    rgb_pixel_t rgb_expected[$];

    bit sender_paced   = 1'b1;
    bit receiver_paced = 1'b1;
    int holds_requested = 0;
    int holds_granted   = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;

    int pixels_sent     = 0;
    int pixels_checked  = 0;
    int bad_hue_seen    = 0;
    int mismatch_count  = 0;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Six-sector mapping with exact integer terms, truncated once
    function automatic rgb_pixel_t convert_hsv(input hsv_pixel_t px);
        int unsigned h;
        int unsigned s;
        int unsigned v;
        int unsigned rem;
        logic [7:0]  val;
        logic [7:0]  term_p;
        logic [7:0]  term_q;
        logic [7:0]  term_t;
        sector_t     sec;
        rgb_pixel_t  rgb;
        rgb = '0;
        h = px.hue;
        s = px.saturation;
        v = px.brightness;
        if (h >= HUE_LIMIT)
        begin
            rgb.bad_hue = 1'b1;
        end
        else
        begin
            sec    = sector_t'(h / DEG_PER_SECTOR);
            rem    = h % DEG_PER_SECTOR;
            val    = px.brightness;
            term_p = 8'((v * (FULL_SCALE - s)) / FULL_SCALE);
            term_q = 8'((v * (SECTOR_SCALE - s * rem)) / SECTOR_SCALE);
            term_t = 8'((v * (SECTOR_SCALE - s * (DEG_PER_SECTOR - rem)))
                        / SECTOR_SCALE);
            case (sec)
                SECTOR_RED_YELLOW:   {rgb.red, rgb.green, rgb.blue} = {val, term_t, term_p};
                SECTOR_YELLOW_GREEN: {rgb.red, rgb.green, rgb.blue} = {term_q, val, term_p};
                SECTOR_GREEN_CYAN:   {rgb.red, rgb.green, rgb.blue} = {term_p, val, term_t};
                SECTOR_CYAN_BLUE:    {rgb.red, rgb.green, rgb.blue} = {term_p, term_q, val};
                SECTOR_BLUE_MAGENTA: {rgb.red, rgb.green, rgb.blue} = {term_t, term_p, val};
                default:             {rgb.red, rgb.green, rgb.blue} = {val, term_p, term_q};
            endcase
        end
        return rgb;
    endfunction

    function automatic hsv_pixel_t hsv_of(input int h, input int s, input int v);
        hsv_pixel_t px;
        px.hue        = 9'(h);
        px.saturation = 8'(s);
        px.brightness = 8'(v);
        return px;
    endfunction

    // Pick a fraction field, leaning on both ends of the scale
    function automatic logic [7:0] random_fraction();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return 8'd0;
        else if (pick < 20)
            return 8'd255;
        else
            return 8'($urandom_range(255));
    endfunction

    // Mostly valid hues, about one in ten out of range
    function automatic hsv_pixel_t random_pixel();
        hsv_pixel_t px;
        if ($urandom_range(99) < 10)
            px.hue = 9'($urandom_range(511, 360));
        else
            px.hue = 9'($urandom_range(359));
        px.saturation = random_fraction();
        px.brightness = random_fraction();
        return px;
    endfunction

    // Offer one pixel, hold it until taken, then record its prediction
    task automatic send_pixel(input hsv_pixel_t px);
        while (sender_paced && $urandom_range(99) < IDLE_PERCENT)
        begin
            hsv_ch.valid <= 1'b0;
            @(posedge clk);
        end
        hsv_ch.valid <= 1'b1;
        hsv_ch.data  <= px;
        do
            @(posedge clk);
        while (!hsv_ch.ready);
        rgb_expected.push_back(convert_hsv(px));
        pixels_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pixel(random_pixel());
    endtask

    // Sector edges, field extremes, zero saturation and out-of-range hues
    task automatic test_directed();
        send_pixel(hsv_of(0,   255, 255));
        send_pixel(hsv_of(59,  255, 255));
        send_pixel(hsv_of(60,  255, 255));
        send_pixel(hsv_of(119, 200, 180));
        send_pixel(hsv_of(120, 255, 255));
        send_pixel(hsv_of(179, 128, 255));
        send_pixel(hsv_of(180, 255, 200));
        send_pixel(hsv_of(239, 255, 255));
        send_pixel(hsv_of(240, 90,  255));
        send_pixel(hsv_of(299, 255, 100));
        send_pixel(hsv_of(300, 255, 255));
        send_pixel(hsv_of(359, 255, 255));
        send_pixel(hsv_of(30,  0,   173));
        send_pixel(hsv_of(210, 0,   255));
        send_pixel(hsv_of(45,  255, 0));
        send_pixel(hsv_of(0,   0,   0));
        send_pixel(hsv_of(255, 170, 85));
        send_pixel(hsv_of(256, 85,  170));
        send_pixel(hsv_of(330, 1,   254));
        send_pixel(hsv_of(150, 127, 128));
        send_pixel(hsv_of(360, 255, 255));
        send_pixel(hsv_of(511, 255, 255));
        send_pixel(hsv_of(448, 0,   0));
    endtask

    task automatic test_random_mix();
        send_random(380);
    endtask

    // Full rate on both sides
    task automatic test_back_to_back();
        sender_paced   = 1'b0;
        receiver_paced = 1'b0;
        send_random(150);
        sender_paced   = 1'b1;
        receiver_paced = 1'b1;
    endtask

    // Hold the output long enough for every stage to fill
    task automatic test_output_hold();
        holds_requested++;
        send_random(40);
    endtask

    task automatic test_random_tail();
        send_random(160);
    endtask

    // Receiver: random stalls, or a long hold when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            rgb_ch.ready <= 1'b0;
        end
        else if (holds_granted != holds_requested)
        begin
            holds_granted++;
            hold_left = HOLD_CYCLES - 1;
            rgb_ch.ready <= 1'b0;
        end
        else
        begin
            rgb_ch.ready <= !receiver_paced || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        rgb_pixel_t want;
        if (rst_n && rgb_ch.valid && rgb_ch.ready)
        begin
            if (rgb_expected.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("[%0t] unexpected result r=%0d g=%0d b=%0d bad=%0b",
                             $realtime, rgb_ch.data.red, rgb_ch.data.green,
                             rgb_ch.data.blue, rgb_ch.data.bad_hue);
            end
            else
            begin
                want = rgb_expected.pop_front();
                pixels_checked++;
                if (want.bad_hue)
                    bad_hue_seen++;
                if (rgb_ch.data.red !== want.red || rgb_ch.data.green !== want.green ||
                    rgb_ch.data.blue !== want.blue ||
                    rgb_ch.data.bad_hue !== want.bad_hue)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"[%0t] result %0d: expected r=%0d g=%0d b=%0d bad=%0b,",
                                  " got r=%0d g=%0d b=%0d bad=%0b"},
                                 $realtime, pixels_checked, want.red, want.green,
                                 want.blue, want.bad_hue, rgb_ch.data.red,
                                 rgb_ch.data.green, rgb_ch.data.blue,
                                 rgb_ch.data.bad_hue);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (hsv_ch.valid && hsv_ch.ready) || (rgb_ch.valid && rgb_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, rgb_expected.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sequence
    initial
    begin
        rst_n        = 1'b0;
        hsv_ch.valid = 1'b0;
        hsv_ch.data  = '0;
        rgb_ch.ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix();
        test_back_to_back();
        test_output_hold();
        test_random_tail();

        // Drop valid and drain the pipe
        hsv_ch.valid <= 1'b0;
        while (rgb_expected.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Converted %0d pixels, %0d checked, %0d with out-of-range hue, %0d mismatches.",
                 pixels_sent, pixels_checked, bad_hue_seen, mismatch_count);
        $display({"Traffic: sector edges and extremes, random idling, full-rate burst,",
                  " %0d-cycle output hold."}, HOLD_CYCLES);
        if (mismatch_count == 0 && rgb_expected.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
